/* rtl/assert_macros.svh */
// assertion macros shared by the centroid rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vic assertion failed");
`define VIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vic assertion failed");
`else
`define VIC_ASSERT(lbl, clk, rst_n, prop)
`define VIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/vic_pkg.sv */
// shared types and constants of the volume centroid block
`timescale 1ns / 1ps
package vic_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int VOXEL_W    = 8;
  localparam int COORD_W    = 16;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_e;

endpackage

/* rtl/vic_front.sv */
// front end: scan position counters and running intensity and moment sums
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vic_front import vic_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CFG_DATA_W-1:0] size_x_i,
  input  logic [CFG_DATA_W-1:0] size_y_i,
  input  logic [CFG_DATA_W-1:0] size_z_i,
  input  logic                  push_i,
  input  logic [VOXEL_W-1:0]    voxel_i,
  output logic                  full_o,
  input  logic                  job_full_i,
  output logic                  job_push_o,
  output logic [$clog2(MAX_DIM)*15+32-1:0] job_data_o
);

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int MASS_W = VOXEL_W + 3 * POS_W;
  localparam int MOM_W  = MASS_W + POS_W;
  localparam int PROD_W = POS_W + VOXEL_W;
  localparam int SZ_W   = ($clog2(MAX_DIM + 1) > CFG_DATA_W) ?
                          $clog2(MAX_DIM + 1) : CFG_DATA_W;

  logic [POS_W-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [MASS_W-1:0] mass_q, mass_d, mass_nx;
  logic [MOM_W-1:0]  mx_q, mx_d, mx_nx;
  logic [MOM_W-1:0]  my_q, my_d, my_nx;
  logic [MOM_W-1:0]  mz_q, mz_d, mz_nx;
  logic [SZ_W-1:0]   eff_x, eff_y, eff_z;
  logic [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic              wrap_x, wrap_y, wrap_z, last, acc;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] r);
    logic [SZ_W-1:0] e;
    e = SZ_W'(r);
    if (e == '0) begin
      e = SZ_W'(1);
    end else if (e > SZ_W'(MAX_DIM)) begin
      e = SZ_W'(MAX_DIM);
    end
    return e;
  endfunction

  function automatic logic at_end(input logic [POS_W-1:0] p, input logic [SZ_W-1:0] s);
    return ((SZ_W+1)'(p) + (SZ_W+1)'(1)) >= (SZ_W+1)'(s);
  endfunction

  always_comb begin
    eff_x  = eff_size(size_x_i);
    eff_y  = eff_size(size_y_i);
    eff_z  = eff_size(size_z_i);
    wrap_z = at_end(pos_z_q, eff_z);
    wrap_y = at_end(pos_y_q, eff_y);
    wrap_x = at_end(pos_x_q, eff_x);
    last   = wrap_z & wrap_y & wrap_x;

    // only the closing word of a volume waits for room in the job queue
    full_o     = last & job_full_i;
    acc        = push_i & ~full_o;
    job_push_o = acc & last;

    prod_x  = PROD_W'(pos_x_q) * PROD_W'(voxel_i);
    prod_y  = PROD_W'(pos_y_q) * PROD_W'(voxel_i);
    prod_z  = PROD_W'(pos_z_q) * PROD_W'(voxel_i);
    mass_nx = mass_q + MASS_W'(voxel_i);
    mx_nx   = mx_q + MOM_W'(prod_x);
    my_nx   = my_q + MOM_W'(prod_y);
    mz_nx   = mz_q + MOM_W'(prod_z);
    job_data_o = {mass_nx, mx_nx, my_nx, mz_nx};

    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    mass_d  = mass_q;
    mx_d    = mx_q;
    my_d    = my_q;
    mz_d    = mz_q;
    if (acc) begin
      pos_z_d = wrap_z ? '0 : pos_z_q + POS_W'(1);
      if (wrap_z) begin
        pos_y_d = wrap_y ? '0 : pos_y_q + POS_W'(1);
      end
      if (wrap_z && wrap_y) begin
        pos_x_d = wrap_x ? '0 : pos_x_q + POS_W'(1);
      end
      if (last) begin
        mass_d = '0;
        mx_d   = '0;
        my_d   = '0;
        mz_d   = '0;
      end else begin
        mass_d = mass_nx;
        mx_d   = mx_nx;
        my_d   = my_nx;
        mz_d   = mz_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      mass_q  <= '0;
      mx_q    <= '0;
      my_q    <= '0;
      mz_q    <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      mass_q  <= mass_d;
      mx_q    <= mx_d;
      my_q    <= my_d;
      mz_q    <= mz_d;
    end
  end

  `VIC_ASSERT_NEXT(a_front_clear, clk_i, rst_ni, job_push_o, mass_q == '0 && pos_z_q == '0)

endmodule

/* rtl/vic_queue.sv */
// small register queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vic_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  always_comb begin
    full_o  = cnt_q == CW'(DEPTH);
    empty_o = cnt_q == '0;
    data_o  = slot_q[rd_q];
    do_push = push_i & ~full_o;
    do_pop  = pop_i & ~empty_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  `VIC_ASSERT(a_queue_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `VIC_ASSERT(a_queue_no_overrun, clk_i, rst_ni, !(push_i && full_o))

endmodule

/* rtl/vic_div.sv */
// restoring divider, one quotient bit per step, for moment * 256 / mass
`timescale 1ns / 1ps
module vic_div #(
  parameter int MAX_DIM = 256
) (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic                                 step_i,
  input  logic [$clog2(MAX_DIM)*4+8-1:0]       moment_i,
  input  logic [$clog2(MAX_DIM)*3+8-1:0]       mass_i,
  output logic [$clog2(MAX_DIM)+8-1:0]         quo_o
);

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int MASS_W = 3 * POS_W + 8;
  localparam int MOM_W  = MASS_W + POS_W;
  localparam int QW     = POS_W + 8;

  logic [MASS_W-1:0] rem_q, dvs_q;
  logic [QW-1:0]     quo_q;
  logic [MASS_W:0]   t, diff;
  logic              ge;

  // quotient is known to fit in QW bits, so the top of the dividend
  // already sits below the divisor and only QW steps remain
  always_comb begin
    t     = {rem_q, quo_q[QW-1]};
    diff  = t - {1'b0, dvs_q};
    ge    = t >= {1'b0, dvs_q};
    quo_o = quo_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= moment_i[MOM_W-1:POS_W];
      quo_q <= {moment_i[POS_W-1:0], 8'd0};
      dvs_q <= mass_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[MASS_W-1:0] : t[MASS_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

endmodule

/* rtl/vic_back.sv */
// back end: sequencer for the three dividers and the result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vic_back import vic_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_empty_i,
  input  logic [$clog2(MAX_DIM)*15+32-1:0] job_data_i,
  output logic                  job_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [COORD_W-1:0]    center_x_o,
  output logic [COORD_W-1:0]    center_y_o,
  output logic [COORD_W-1:0]    center_z_o,
  output logic                  empty_res_o
);

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int MASS_W = 3 * POS_W + VOXEL_W;
  localparam int MOM_W  = MASS_W + POS_W;
  localparam int QW     = POS_W + 8;
  localparam int CNT_W  = $clog2(QW);
  localparam int EXT_W  = QW + COORD_W;

  bk_state_e         state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              res_valid_q, res_valid_d;
  logic [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic              er_q;
  logic [MASS_W-1:0] job_mass;
  logic [MOM_W-1:0]  job_mx, job_my, job_mz;
  logic [QW-1:0]     qx, qy, qz;
  logic              div_load, div_step, res_wr, res_empty, slot_free;

  function automatic logic [COORD_W-1:0] sat(input logic [QW-1:0] q);
    logic [EXT_W-1:0] e;
    e = EXT_W'(q);
    return (e > EXT_W'({COORD_W{1'b1}})) ? {COORD_W{1'b1}} : e[COORD_W-1:0];
  endfunction

  assign {job_mass, job_mx, job_my, job_mz} = job_data_i;

  vic_div #(.MAX_DIM(MAX_DIM)) u_div_x (
    .clk_i(clk_i), .load_i(div_load), .step_i(div_step),
    .moment_i(job_mx), .mass_i(job_mass), .quo_o(qx)
  );
  vic_div #(.MAX_DIM(MAX_DIM)) u_div_y (
    .clk_i(clk_i), .load_i(div_load), .step_i(div_step),
    .moment_i(job_my), .mass_i(job_mass), .quo_o(qy)
  );
  vic_div #(.MAX_DIM(MAX_DIM)) u_div_z (
    .clk_i(clk_i), .load_i(div_load), .step_i(div_step),
    .moment_i(job_mz), .mass_i(job_mass), .quo_o(qz)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    div_load  = 1'b0;
    div_step  = 1'b0;
    res_wr    = 1'b0;
    res_empty = 1'b0;
    slot_free = ~res_valid_q | pop_i;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          if (job_mass == '0) begin
            // empty volume skips the dividers
            if (slot_free) begin
              job_pop_o = 1'b1;
              res_wr    = 1'b1;
              res_empty = 1'b1;
            end
          end else begin
            job_pop_o = 1'b1;
            div_load  = 1'b1;
            cnt_d     = '0;
            state_d   = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        div_step = 1'b1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          res_wr  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
    res_valid_d = res_wr | (res_valid_q & ~pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_wr) begin
      cx_q <= res_empty ? '0 : sat(qx);
      cy_q <= res_empty ? '0 : sat(qy);
      cz_q <= res_empty ? '0 : sat(qz);
      er_q <= res_empty;
    end
  end

  assign empty_o     = ~res_valid_q;
  assign center_x_o  = cx_q;
  assign center_y_o  = cy_q;
  assign center_z_o  = cz_q;
  assign empty_res_o = er_q;

  `VIC_ASSERT_NEXT(a_back_empty_vol, clk_i, rst_ni, job_pop_o && job_mass == '0, res_valid_q && er_q)

endmodule

/* rtl/volume_intensity_centroid.sv */
// top level of the intensity-weighted 3d centroid block
// voxels are taken one word per cycle; only the last word of a volume can stall, and
// only while two finished volumes still wait for the dividers
// per volume the dividers produce log2(MAX_DIM)+8 quotient bits (16 at 256); the sums pass
// through the job queue, the dividers and BK_DONE into the result word (all-zero volumes skip the dividers)
// reset clears counters, sums, the job queue and the result valid flag; sizes reset to 256 on each axis
`timescale 1ns / 1ps
module volume_intensity_centroid import vic_pkg::*; #(
  parameter int MAX_DIM = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // voxel side
  input  logic                  push,
  output logic                  full,
  input  logic [VOXEL_W-1:0]    voxel_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_W-1:0]    center_x_o,
  output logic [COORD_W-1:0]    center_y_o,
  output logic [COORD_W-1:0]    center_z_o,
  output logic                  empty_res_o
);

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int MASS_W = 3 * POS_W + VOXEL_W;
  localparam int MOM_W  = MASS_W + POS_W;
  // one job word: intensity sum and the three moments of a finished volume
  localparam int JOB_W  = MASS_W + 3 * MOM_W;

  logic [CFG_DATA_W-1:0] size_x_q, size_y_q, size_z_q;
  logic                  job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0]      job_wdata, job_rdata;

  // size registers, writable at any time the channel is valid
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SIZE_X: size_x_q <= cfg_data_i;
        CFG_SIZE_Y: size_y_q <= cfg_data_i;
        CFG_SIZE_Z: size_z_q <= cfg_data_i;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front: scan counters and accumulators, hands off sums at volume end
  vic_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_x_i   (size_x_q),
    .size_y_i   (size_y_q),
    .size_z_i   (size_z_q),
    .push_i     (push),
    .voxel_i    (voxel_i),
    .full_o     (full),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_data_o (job_wdata)
  );

  // two-deep job queue decouples accumulation from division
  vic_queue #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_rdata),
    .empty_o (job_empty)
  );

  // back: three bit-serial dividers running side by side, then the result register
  vic_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_data_i  (job_rdata),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .center_x_o  (center_x_o),
    .center_y_o  (center_y_o),
    .center_z_o  (center_z_o),
    .empty_res_o (empty_res_o)
  );

endmodule
